// ===== sv/alias_table_build_and_sample_macros.svh =====
// Assertion macros shared by the alias table checker.
`ifndef ALIAS_TABLE_BUILD_AND_SAMPLE_MACROS_SVH
`define ALIAS_TABLE_BUILD_AND_SAMPLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ATB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ATB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/atb_pkg.sv =====
// Package: widths, codes and controller/datapath interface types for the alias table.
`timescale 1ns / 1ps

package atb_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int W_W             = FRAC_BITS + 1;
    localparam int RAND_W          = FRAC_BITS;
    localparam int ENTRY_W         = 6;
    localparam int KIND_W          = 2;
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int ONE_FIX         = 1 << FRAC_BITS;

    // input tdata layout, lowest field first
    localparam int S_FIELDS_W = W_W + 2 * RAND_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int RCOL_LSB   = W_W;
    localparam int RCOIN_LSB  = W_W + RAND_W;

    // result tdata layout, lowest field first
    localparam int M_FIELDS_W = 2 * ENTRY_W + W_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ENTRY    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NO_TABLE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SC_RD,
        ST_SC_WR,
        ST_PAIR_POP,
        ST_PAIR_RD,
        ST_PAIR_UPD,
        ST_LEFT_POP,
        ST_LEFT_WR,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_SAMP_RD,
        ST_SAMP_OUT
    } atb_state_t;

    typedef struct packed {
        logic load_wr;
        logic build_start;
        logic samp_start;
        logic sc_rd;
        logic sc_wr;
        logic pair_pop;
        logic pair_rd;
        logic pair_upd;
        logic left_pop;
        logic left_wr;
        logic idx_clr;
        logic emit_rd;
        logic emit_out;
        logic samp_rd;
        logic samp_out;
    } atb_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic pair_go;
        logic left_go;
        logic slot_free;
    } atb_status_t;

endpackage

// ===== sv/alias_table_build_and_sample.sv =====
// Top level of the alias table builder and sampler.
// Input channel s_*: one item per handshake. tuser selects the operation: load one weight
// or draw one sample. A load carrying tlast closes the set of weights and starts the build.
// Result channel m_*: tuser gives the kind (table entry, sample, sample with no table),
// tlast marks the final entry of a build and every sample.
// A load without tlast gives no result; the next item is taken in the following cycle.
// A sample is taken into the column and coin registers, its column is read from the table
// memories, and its result then enters the output register; no item is taken meanwhile.
// The build is run by the sequencer over single-port stack memories: each entry is read
// and written back scaled; each pairing step pops, reads and updates, and a final check
// ends the pairing; each leftover entry is popped and written, and a final check ends that
// phase; then each entry is read and emitted, waiting while the receiver stalls. No items are taken meanwhile.
// Loads beyond MAX_ENTRIES weights are dropped. A sample before any table gives a
// no-table result. Reset empties the table and the result register; memories are not
// cleared since nothing is read before it is written.
// When the receiver stalls, the held result stays in the output register and the
// sequencer waits before writing the next one; no item is taken until it is written.
`timescale 1ns / 1ps

module alias_table_build_and_sample import atb_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // weight [16:0], rand_column [32:17], rand_coin [48:33], zero fill above
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // entry [5:0], prob [22:6], partner [28:23], zero fill above
    output logic [M_TDATA_W-1:0] m_tdata,
    // result_kind
    output logic [KIND_W-1:0]    m_tuser,
    output logic                 m_tlast
);

    atb_cmd_t           cmd;
    atb_status_t        sts;
    logic [ENTRY_W-1:0] entry;
    logic [W_W-1:0]     prob;
    logic [ENTRY_W-1:0] partner;

    atb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    atb_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .weight      (s_tdata[W_W-1:0]),
        .rand_column (s_tdata[RCOL_LSB+RAND_W-1:RCOL_LSB]),
        .rand_coin   (s_tdata[RCOIN_LSB+RAND_W-1:RCOIN_LSB]),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_kind      (m_tuser),
        .m_entry     (entry),
        .m_prob      (prob),
        .m_partner   (partner),
        .m_last      (m_tlast)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, partner, prob, entry};

endmodule

// ===== sv/atb_ctrl.sv =====
// Sequencer for loading, table build, entry emission and sampling.
`timescale 1ns / 1ps

module atb_ctrl import atb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tuser,
    input  logic        s_tlast,
    output logic        s_tready,
    input  atb_status_t sts,
    output atb_cmd_t    cmd
);

    atb_state_t state_reg;
    atb_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == FUNC_LOAD) begin
                        cmd.load_wr = 1'b1;
                        if (s_tlast) begin
                            cmd.build_start = 1'b1;
                            state_next      = ST_SC_RD;
                        end
                    end else begin
                        cmd.samp_start = 1'b1;
                        state_next     = ST_SAMP_RD;
                    end
                end
            end
            ST_SC_RD: begin
                cmd.sc_rd  = 1'b1;
                state_next = ST_SC_WR;
            end
            ST_SC_WR: begin
                cmd.sc_wr  = 1'b1;
                state_next = sts.scan_last ? ST_PAIR_POP : ST_SC_RD;
            end
            ST_PAIR_POP: begin
                if (sts.pair_go) begin
                    cmd.pair_pop = 1'b1;
                    state_next   = ST_PAIR_RD;
                end else begin
                    state_next = ST_LEFT_POP;
                end
            end
            ST_PAIR_RD: begin
                cmd.pair_rd = 1'b1;
                state_next  = ST_PAIR_UPD;
            end
            ST_PAIR_UPD: begin
                cmd.pair_upd = 1'b1;
                state_next   = ST_PAIR_POP;
            end
            ST_LEFT_POP: begin
                if (sts.left_go) begin
                    cmd.left_pop = 1'b1;
                    state_next   = ST_LEFT_WR;
                end else begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_EMIT_RD;
                end
            end
            ST_LEFT_WR: begin
                cmd.left_wr = 1'b1;
                state_next  = ST_LEFT_POP;
            end
            ST_EMIT_RD: begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (sts.slot_free) begin
                    cmd.emit_out = 1'b1;
                    state_next   = sts.scan_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_SAMP_RD: begin
                cmd.samp_rd = 1'b1;
                state_next  = ST_SAMP_OUT;
            end
            ST_SAMP_OUT: begin
                if (sts.slot_free) begin
                    cmd.samp_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/atb_datapath.sv =====
// Weight store, stacks, alias table memories, sampler and result register.
`timescale 1ns / 1ps

module atb_datapath import atb_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  atb_cmd_t            cmd,
    output atb_status_t         sts,
    input  logic [W_W-1:0]      weight,
    input  logic [RAND_W-1:0]   rand_column,
    input  logic [RAND_W-1:0]   rand_coin,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [KIND_W-1:0]   m_kind,
    output logic [ENTRY_W-1:0]  m_entry,
    output logic [W_W-1:0]      m_prob,
    output logic [ENTRY_W-1:0]  m_partner,
    output logic                m_last
);

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SW_W   = W_W + CNT_W;
    localparam int CP_W   = CNT_W + RAND_W;
    localparam logic [SW_W-1:0]  ONE_SW  = SW_W'(ONE_FIX);
    localparam logic [W_W-1:0]   ONE_W   = W_W'(ONE_FIX);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    // memories
    logic [SW_W-1:0]  sw_mem [MAX_ENTRIES];
    logic [IDX_W-1:0] ss_mem [MAX_ENTRIES];
    logic [IDX_W-1:0] ls_mem [MAX_ENTRIES];
    logic [W_W-1:0]   pr_mem [MAX_ENTRIES];
    logic [IDX_W-1:0] pt_mem [MAX_ENTRIES];

    // control state
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ready_reg;
    logic [CNT_W-1:0] small_top_reg, small_top_next;
    logic [CNT_W-1:0] large_top_reg, large_top_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg;

    // registered read data and sample operands
    logic [SW_W-1:0]   sw_a_reg, sw_b_reg;
    logic [IDX_W-1:0]  ss_rd_reg, ls_rd_reg;
    logic [W_W-1:0]    pr_rd_reg;
    logic [IDX_W-1:0]  pt_rd_reg;
    logic              left_sel_reg;
    logic [IDX_W-1:0]  col_reg;
    logic [RAND_W-1:0] coin_reg;
    logic              nt_reg;

    // result register payload
    logic [KIND_W-1:0]  m_kind_reg;
    logic [ENTRY_W-1:0] m_entry_reg;
    logic [W_W-1:0]     m_prob_reg;
    logic [ENTRY_W-1:0] m_partner_reg;
    logic               m_last_reg;

    logic [CNT_W-1:0] load_base;
    logic             load_room;
    logic [SW_W-1:0]  scaled_w;
    logic [SW_W-1:0]  upd_w;
    logic [CNT_W-1:0] st_dec, lt_dec;
    logic             push_en, push_large;
    logic [IDX_W-1:0] push_val;
    logic [IDX_W-1:0] left_e;
    logic [CP_W-1:0]  col_prod;
    logic [CNT_W-1:0] col_raw, col_clamp;
    logic [IDX_W-1:0] pick;
    logic             slot_free;

    // a new load after a build restarts the count
    assign load_base = ready_reg ? '0 : count_reg;
    assign load_room = load_base < MAX_CNT;

    assign scaled_w = SW_W'(sw_a_reg[W_W-1:0]) * SW_W'(count_reg);
    // more holds > 1.0 so this cannot go negative
    assign upd_w    = sw_b_reg + sw_a_reg - ONE_SW;

    assign st_dec = small_top_reg - CNT_W'(1);
    assign lt_dec = large_top_reg - CNT_W'(1);
    assign left_e = left_sel_reg ? ls_rd_reg : ss_rd_reg;

    assign col_prod  = CP_W'(count_reg) * CP_W'(rand_column);
    assign col_raw   = col_prod[CP_W-1:RAND_W];
    assign col_clamp = (col_raw >= count_reg) ? (count_reg - CNT_W'(1)) : col_raw;
    assign pick      = ({1'b0, coin_reg} < pr_rd_reg) ? col_reg : pt_rd_reg;

    assign slot_free = !m_valid_reg || m_ready;

    assign sts.scan_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign sts.pair_go   = (small_top_reg != '0) && (large_top_reg != '0);
    assign sts.left_go   = (small_top_reg != '0) || (large_top_reg != '0);
    assign sts.slot_free = slot_free;

    always_comb begin
        push_en    = 1'b0;
        push_large = 1'b0;
        push_val   = idx_reg;
        if (cmd.sc_wr) begin
            push_en    = 1'b1;
            push_large = scaled_w > ONE_SW;
        end else if (cmd.pair_upd) begin
            push_en    = 1'b1;
            push_large = upd_w > ONE_SW;
            push_val   = ls_rd_reg;
        end
    end

    always_comb begin
        count_next     = count_reg;
        small_top_next = small_top_reg;
        large_top_next = large_top_reg;
        idx_next       = idx_reg;
        if (cmd.load_wr) begin
            count_next = load_base + CNT_W'(load_room);
        end
        if (cmd.build_start) begin
            small_top_next = '0;
            large_top_next = '0;
        end
        if (cmd.pair_pop) begin
            small_top_next = st_dec;
            large_top_next = lt_dec;
        end
        if (cmd.left_pop) begin
            if (small_top_reg != '0) begin
                small_top_next = st_dec;
            end else begin
                large_top_next = lt_dec;
            end
        end
        if (push_en) begin
            if (push_large) begin
                if (large_top_reg < MAX_CNT) begin
                    large_top_next = large_top_reg + CNT_W'(1);
                end
            end else if (small_top_reg < MAX_CNT) begin
                small_top_next = small_top_reg + CNT_W'(1);
            end
        end
        if (cmd.build_start || cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.sc_wr || cmd.emit_out) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            ready_reg     <= 1'b0;
            small_top_reg <= '0;
            large_top_reg <= '0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            count_reg     <= count_next;
            small_top_reg <= small_top_next;
            large_top_reg <= large_top_next;
            idx_reg       <= idx_next;
            if (cmd.load_wr) begin
                ready_reg <= 1'b0;
            end else if (cmd.emit_out && sts.scan_last) begin
                ready_reg <= 1'b1;
            end
            if (cmd.emit_out || cmd.samp_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // scaled weight store: one write port, two read ports
    always_ff @(posedge aclk) begin
        if (cmd.load_wr && load_room) begin
            sw_mem[load_base[IDX_W-1:0]] <= SW_W'(weight);
        end else if (cmd.sc_wr) begin
            sw_mem[idx_reg] <= scaled_w;
        end else if (cmd.pair_upd) begin
            sw_mem[ls_rd_reg] <= upd_w;
        end
        if (cmd.sc_rd) begin
            sw_a_reg <= sw_mem[idx_reg];
        end else if (cmd.pair_rd) begin
            sw_a_reg <= sw_mem[ss_rd_reg];
            sw_b_reg <= sw_mem[ls_rd_reg];
        end
    end

    // small and large stacks
    always_ff @(posedge aclk) begin
        if (push_en && push_large && (large_top_reg < MAX_CNT)) begin
            ls_mem[large_top_reg[IDX_W-1:0]] <= push_val;
        end
        if (push_en && !push_large && (small_top_reg < MAX_CNT)) begin
            ss_mem[small_top_reg[IDX_W-1:0]] <= push_val;
        end
        if (cmd.pair_pop) begin
            ss_rd_reg <= ss_mem[st_dec[IDX_W-1:0]];
            ls_rd_reg <= ls_mem[lt_dec[IDX_W-1:0]];
        end else if (cmd.left_pop) begin
            left_sel_reg <= (small_top_reg == '0);
            if (small_top_reg != '0) begin
                ss_rd_reg <= ss_mem[st_dec[IDX_W-1:0]];
            end else begin
                ls_rd_reg <= ls_mem[lt_dec[IDX_W-1:0]];
            end
        end
    end

    // alias table: probability and partner
    always_ff @(posedge aclk) begin
        if (cmd.pair_upd) begin
            pr_mem[ss_rd_reg] <= sw_a_reg[W_W-1:0];
            pt_mem[ss_rd_reg] <= ls_rd_reg;
        end else if (cmd.left_wr) begin
            pr_mem[left_e] <= ONE_W;
            pt_mem[left_e] <= left_e;
        end
        if (cmd.emit_rd) begin
            pr_rd_reg <= pr_mem[idx_reg];
            pt_rd_reg <= pt_mem[idx_reg];
        end else if (cmd.samp_rd) begin
            pr_rd_reg <= pr_mem[col_reg];
            pt_rd_reg <= pt_mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.samp_start) begin
            col_reg  <= col_clamp[IDX_W-1:0];
            coin_reg <= rand_coin;
            nt_reg   <= !ready_reg || (count_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_out) begin
            m_kind_reg    <= KIND_ENTRY;
            m_entry_reg   <= ENTRY_W'(idx_reg);
            m_prob_reg    <= pr_rd_reg;
            m_partner_reg <= ENTRY_W'(pt_rd_reg);
            m_last_reg    <= sts.scan_last;
        end else if (cmd.samp_out) begin
            m_kind_reg    <= nt_reg ? KIND_NO_TABLE : KIND_SAMPLE;
            m_entry_reg   <= nt_reg ? '0 : ENTRY_W'(pick);
            m_prob_reg    <= '0;
            m_partner_reg <= '0;
            m_last_reg    <= 1'b1;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_kind    = m_kind_reg;
    assign m_entry   = m_entry_reg;
    assign m_prob    = m_prob_reg;
    assign m_partner = m_partner_reg;
    assign m_last    = m_last_reg;

endmodule

// ===== sv/atb_checker.sv =====
// Port-level checks for the alias table block, bound to the top level.
`timescale 1ns / 1ps
`include "alias_table_build_and_sample_macros.svh"

module atb_checker import atb_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]    m_tuser,
    input logic                 m_tlast
);

    `ATB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result item changed while stalled")
    `ATB_ASSERT_NOW(a_sample_shape, m_tvalid && m_tuser != KIND_ENTRY, m_tlast && m_tdata[ENTRY_W+W_W-1:ENTRY_W] == '0 && m_tdata[2*ENTRY_W+W_W-1:ENTRY_W+W_W] == '0, "sample result with prob or partner set, or without last")
    `ATB_ASSERT_NOW(a_no_table_entry, m_tvalid && m_tuser == KIND_NO_TABLE, m_tdata[ENTRY_W-1:0] == '0, "no-table result with nonzero entry")
    `ATB_ASSERT_NEXT(a_sample_busy, s_tvalid && s_tready && s_tuser == FUNC_SAMPLE, !s_tready, "item taken while a sample is still being looked up")

endmodule

bind alias_table_build_and_sample atb_checker u_atb_checker (.*);
